/* rtl/core/tbpre_pkg.sv */
// Types and constants of the tape bit pulse run encoder.
package tbpre_pkg;

    localparam int DIV_W     = 20;
    localparam int COUNT_W   = 12;
    localparam int DUR_W     = 16;
    localparam int LEVEL_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    localparam logic [DIV_W-1:0]   US_PER_SEC  = 20'd1000000;
    localparam logic [DUR_W-1:0]   TRAILER_US  = 16'd2000;
    localparam logic [COUNT_W-1:0] MAX_SAMPLES = 12'd4095;

    localparam logic [1:0] CMD_LEAD   = 2'd0;
    localparam logic [1:0] CMD_DATA   = 2'd1;
    localparam logic [1:0] CMD_TRAIL  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_US        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_US      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEAD_US       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LEVEL    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SILENCE_LEVEL = 3'd6;

    typedef enum logic [1:0] {
        CAL_IDLE,
        CAL_LOAD,
        CAL_DIV,
        CAL_STORE
    } cal_state_t;

    typedef enum logic [2:0] {
        JOB_PERIOD,
        JOB_LEAD,
        JOB_TRAIL,
        JOB_PULSE,
        JOB_GAP,
        JOB_HALF
    } cal_job_t;

    typedef enum logic [2:0] {
        RUN_LEAD,
        RUN_TRAIL,
        RUN_GAP,
        RUN_HALF,
        RUN_PULSE
    } run_kind_t;

    typedef struct packed {
        logic load;
        logic step;
        logic store;
        logic busy;
    } cal_ctl_t;

endpackage

/* rtl/core/tape_bit_pulse_run_encoder.sv */
// Top level of the tape bit pulse run encoder: run sample counts, expander and output pipeline.
//
// Usage: each input word on command/data_byte (in_valid/in_ready) expands into runs on
// run_level/run_samples/last_run (out_valid/out_ready); last_run marks the final run of a word.
// A lead-in or trailer word gives one run, a data byte gives two runs per zero bit and four
// runs per one bit, 16 to 32 runs in all; command 3 is accepted and gives nothing.
// The run expander emits one run per cycle when the output is not stalled, so a data byte holds
// the input until its last run leaves, and lead-in or trailer words are taken one per cycle.
// The first run of a word passes the input, expander, run kind and output registers.
// Sample counts are kept in registers and rebuilt by one shared restoring divider, one quotient
// bit per cycle, in six divisions. This pass runs after reset and after every
// configuration write, and in_ready stays low while it runs.
// Reset clears all valid bits and loads the register defaults. When out_ready is low the
// output register holds its run and the stall backs up through the pipeline to in_ready;
// nothing is dropped or repeated.
module tape_bit_pulse_run_encoder (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [tbpre_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tbpre_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           command,
    input  logic [7:0]                           data_byte,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [tbpre_pkg::LEVEL_W-1:0]        run_level,
    output logic [tbpre_pkg::COUNT_W-1:0]        run_samples,
    output logic                                 last_run
);
    import tbpre_pkg::*;

    logic [DUR_W-1:0]   rate_reg;
    logic [DUR_W-1:0]   bit_us_reg;
    logic [DUR_W-1:0]   pulse_us_reg;
    logic [DUR_W-1:0]   lead_us_reg;
    logic [LEVEL_W-1:0] high_level_reg;
    logic [LEVEL_W-1:0] low_level_reg;
    logic [LEVEL_W-1:0] silence_level_reg;

    cal_state_t        cal_state_reg;
    cal_state_t        cal_state_next;
    cal_job_t          job_reg;
    cal_ctl_t          cal_ctl;
    logic [4:0]        step_reg;
    logic [DIV_W-1:0]  dvd_reg;
    logic [DIV_W-1:0]  dsr_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W:0]    div_trial;
    logic [DIV_W:0]    div_diff;
    logic              div_ge;
    logic [DIV_W-1:0]  op_dvd;
    logic [DIV_W-1:0]  op_dsr;
    logic [DUR_W-1:0]  gap_us;
    logic [DUR_W-1:0]  half_us;
    logic [DUR_W+1:0]  rest_us;
    logic [COUNT_W-1:0] quot_sat;

    logic [DIV_W-1:0]   period_reg;
    logic [COUNT_W-1:0] lead_cnt_reg;
    logic [COUNT_W-1:0] trail_cnt_reg;
    logic [COUNT_W-1:0] pulse_cnt_reg;
    logic [COUNT_W-1:0] gap_cnt_reg;
    logic [COUNT_W-1:0] half_cnt_reg;

    logic        a_valid_reg;
    logic [1:0]  a_cmd_reg;
    logic [7:0]  a_byte_reg;
    logic        a_ready;
    logic        in_fire;

    logic        b_valid_reg;
    logic [1:0]  b_cmd_reg;
    logic [7:0]  b_byte_reg;
    logic [2:0]  b_bits_reg;
    logic [1:0]  b_phase_reg;
    run_kind_t   b_kind;
    logic        b_last;
    logic        b_bit_end;
    logic        b_fire;
    logic        b_done;
    logic        b_load;

    logic        c_valid_reg;
    run_kind_t   c_kind_reg;
    logic        c_last_reg;
    logic        c_ready;

    logic               d_valid_reg;
    logic [LEVEL_W-1:0] d_level_reg;
    logic [COUNT_W-1:0] d_samples_reg;
    logic               d_last_reg;
    logic               d_ready;
    logic [LEVEL_W-1:0] sel_level;
    logic [COUNT_W-1:0] sel_samples;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg          <= 16'd44100;
            bit_us_reg        <= 16'd1600;
            pulse_us_reg      <= 16'd150;
            lead_us_reg       <= 16'd2000;
            high_level_reg    <= 8'd255;
            low_level_reg     <= 8'd127;
            silence_level_reg <= 8'd127;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SAMPLE_RATE:   rate_reg          <= cfg_data;
                REG_BIT_US:        bit_us_reg        <= cfg_data;
                REG_PULSE_US:      pulse_us_reg      <= cfg_data;
                REG_LEAD_US:       lead_us_reg       <= cfg_data;
                REG_HIGH_LEVEL:    high_level_reg    <= cfg_data[LEVEL_W-1:0];
                REG_LOW_LEVEL:     low_level_reg     <= cfg_data[LEVEL_W-1:0];
                REG_SILENCE_LEVEL: silence_level_reg <= cfg_data[LEVEL_W-1:0];
                default:           ;
            endcase
        end
    end

    // run durations
    always_comb
    begin
        gap_us  = (bit_us_reg > pulse_us_reg) ? (bit_us_reg - pulse_us_reg) : '0;
        rest_us = {2'b00, bit_us_reg} - {1'b0, pulse_us_reg, 1'b0};
        half_us = (!rest_us[DUR_W+1] && (rest_us != '0)) ? rest_us[DUR_W:1] : '0;
    end

    // count rebuild sequencer
    always_comb
    begin
        cal_state_next = cal_state_reg;
        case (cal_state_reg)
            CAL_IDLE:  cal_state_next = CAL_IDLE;
            CAL_LOAD:  cal_state_next = CAL_DIV;
            CAL_DIV:   cal_state_next = (step_reg == 5'(DIV_W - 1)) ? CAL_STORE : CAL_DIV;
            CAL_STORE: cal_state_next = (job_reg == JOB_HALF) ? CAL_IDLE : CAL_LOAD;
            default:   cal_state_next = CAL_IDLE;
        endcase
        if (cfg_we)
        begin
            cal_state_next = CAL_LOAD;
        end
    end

    always_comb
    begin
        cal_ctl = '0;
        case (cal_state_reg)
            CAL_IDLE:  cal_ctl.busy  = 1'b0;
            CAL_LOAD:
            begin
                cal_ctl.load = 1'b1;
                cal_ctl.busy = 1'b1;
            end
            CAL_DIV:
            begin
                cal_ctl.step = 1'b1;
                cal_ctl.busy = 1'b1;
            end
            CAL_STORE:
            begin
                cal_ctl.store = 1'b1;
                cal_ctl.busy  = 1'b1;
            end
            default:   cal_ctl.busy  = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_state_reg <= CAL_LOAD;
            job_reg       <= JOB_PERIOD;
        end
        else
        begin
            cal_state_reg <= cal_state_next;
            if (cfg_we)
            begin
                job_reg <= JOB_PERIOD;
            end
            else if (cal_ctl.store && (job_reg != JOB_HALF))
            begin
                job_reg <= cal_job_t'(job_reg + 3'd1);
            end
        end
    end

    // divider operands
    always_comb
    begin
        op_dsr = period_reg;
        case (job_reg)
            JOB_PERIOD:
            begin
                op_dvd = US_PER_SEC;
                op_dsr = (rate_reg == '0) ? DIV_W'(1) : DIV_W'(rate_reg);
            end
            JOB_LEAD:  op_dvd = DIV_W'(lead_us_reg);
            JOB_TRAIL: op_dvd = DIV_W'(TRAILER_US);
            JOB_PULSE: op_dvd = DIV_W'(pulse_us_reg);
            JOB_GAP:   op_dvd = DIV_W'(gap_us);
            JOB_HALF:  op_dvd = DIV_W'(half_us);
            default:   op_dvd = '0;
        endcase
    end

    // restoring divider, one quotient bit per cycle
    always_comb
    begin
        div_trial = {rem_reg, dvd_reg[DIV_W-1]};
        div_ge    = div_trial >= {1'b0, dsr_reg};
        div_diff  = div_trial - {1'b0, dsr_reg};
        quot_sat  = (dvd_reg[DIV_W-1:COUNT_W] != '0) ? MAX_SAMPLES : dvd_reg[COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (cal_ctl.load)
        begin
            step_reg <= '0;
        end
        else if (cal_ctl.step)
        begin
            step_reg <= step_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cal_ctl.load)
        begin
            dvd_reg <= op_dvd;
            dsr_reg <= op_dsr;
            rem_reg <= '0;
        end
        else if (cal_ctl.step)
        begin
            rem_reg <= div_ge ? div_diff[DIV_W-1:0] : div_trial[DIV_W-1:0];
            dvd_reg <= {dvd_reg[DIV_W-2:0], div_ge};
        end
        if (cal_ctl.store)
        begin
            case (job_reg)
                JOB_PERIOD: period_reg    <= dvd_reg;
                JOB_LEAD:   lead_cnt_reg  <= quot_sat;
                JOB_TRAIL:  trail_cnt_reg <= quot_sat;
                JOB_PULSE:  pulse_cnt_reg <= quot_sat;
                JOB_GAP:    gap_cnt_reg   <= quot_sat;
                JOB_HALF:   half_cnt_reg  <= quot_sat;
                default:    ;
            endcase
        end
    end

    // stage A: input word
    assign in_fire  = in_valid && in_ready;
    assign a_ready  = !a_valid_reg || b_load;
    assign in_ready = a_ready && !cal_ctl.busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            // drop unused commands here
            a_valid_reg <= in_fire && (command != CMD_UNUSED);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_cmd_reg  <= command;
            a_byte_reg <= data_byte;
        end
    end

    // stage B: run expander
    always_comb
    begin
        b_kind    = RUN_LEAD;
        b_last    = 1'b1;
        b_bit_end = 1'b0;
        case (b_cmd_reg)
            CMD_LEAD:  b_kind = RUN_LEAD;
            CMD_TRAIL: b_kind = RUN_TRAIL;
            CMD_DATA:
            begin
                if (b_byte_reg[7])
                begin
                    b_kind    = b_phase_reg[0] ? RUN_PULSE : RUN_HALF;
                    b_bit_end = (b_phase_reg == 2'd3);
                end
                else
                begin
                    b_kind    = b_phase_reg[0] ? RUN_PULSE : RUN_GAP;
                    b_bit_end = b_phase_reg[0];
                end
                b_last = b_bit_end && (b_bits_reg == '0);
            end
            default:   b_kind = RUN_LEAD;
        endcase
    end

    assign b_fire = b_valid_reg && c_ready;
    assign b_done = b_fire && b_last;
    assign b_load = a_valid_reg && (!b_valid_reg || b_done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_load)
        begin
            b_valid_reg <= 1'b1;
        end
        else if (b_done)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            b_cmd_reg   <= a_cmd_reg;
            b_byte_reg  <= a_byte_reg;
            b_bits_reg  <= 3'd7;
            b_phase_reg <= '0;
        end
        else if (b_fire)
        begin
            if (b_bit_end)
            begin
                b_bits_reg  <= b_bits_reg - 3'd1;
                b_phase_reg <= '0;
                b_byte_reg  <= {b_byte_reg[6:0], 1'b0};
            end
            else
            begin
                b_phase_reg <= b_phase_reg + 2'd1;
            end
        end
    end

    // stage C: run kind
    assign c_ready = !c_valid_reg || d_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_ready)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_fire)
        begin
            c_kind_reg <= b_kind;
            c_last_reg <= b_last;
        end
    end

    // stage D: level and count select, output register
    always_comb
    begin
        case (c_kind_reg)
            RUN_LEAD:
            begin
                sel_level   = silence_level_reg;
                sel_samples = lead_cnt_reg;
            end
            RUN_TRAIL:
            begin
                sel_level   = silence_level_reg;
                sel_samples = trail_cnt_reg;
            end
            RUN_GAP:
            begin
                sel_level   = low_level_reg;
                sel_samples = gap_cnt_reg;
            end
            RUN_HALF:
            begin
                sel_level   = low_level_reg;
                sel_samples = half_cnt_reg;
            end
            RUN_PULSE:
            begin
                sel_level   = high_level_reg;
                sel_samples = pulse_cnt_reg;
            end
            default:
            begin
                sel_level   = high_level_reg;
                sel_samples = pulse_cnt_reg;
            end
        endcase
    end

    assign d_ready = !d_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (d_ready)
        begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_ready && c_valid_reg)
        begin
            d_level_reg   <= sel_level;
            d_samples_reg <= sel_samples;
            d_last_reg    <= c_last_reg;
        end
    end

    assign out_valid   = d_valid_reg;
    assign run_level   = d_level_reg;
    assign run_samples = d_samples_reg;
    assign last_run    = d_last_reg;

endmodule

/* tb/tbpre_run_checker.sv */
// Run checker: predicts the runs of every accepted word and compares each delivered run.
module tbpre_run_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tbpre_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tbpre_pkg::CFG_W-1:0]     cfg_data,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [1:0]                      command,
    input  logic [7:0]                      data_byte,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [tbpre_pkg::LEVEL_W-1:0]   run_level,
    input  logic [tbpre_pkg::COUNT_W-1:0]   run_samples,
    input  logic                            last_run,
    output int                              mismatches,
    output int                              outstanding,
    output int                              runs_checked,
    output int                              words_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import tbpre_pkg::*;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [COUNT_W-1:0] samples;
        logic               last;
    } tape_run_t;

    tape_run_t run_queue[$];

    logic [DUR_W-1:0]   rate_r;
    logic [DUR_W-1:0]   bit_r;
    logic [DUR_W-1:0]   pulse_r;
    logic [DUR_W-1:0]   lead_r;
    logic [LEVEL_W-1:0] high_r;
    logic [LEVEL_W-1:0] low_r;
    logic [LEVEL_W-1:0] silence_r;

    function automatic logic [COUNT_W-1:0] samples_for(int dur_us);
        int rate;
        int period;
        int n;
        rate = (rate_r == '0) ? 1 : int'(rate_r);
        period = int'(US_PER_SEC) / rate;
        if (dur_us <= 0)
        begin
            return '0;
        end
        n = dur_us / period;
        return (n > int'(MAX_SAMPLES)) ? MAX_SAMPLES : n[COUNT_W-1:0];
    endfunction

    function automatic void push_run(logic [LEVEL_W-1:0] level, int dur_us, logic last);
        tape_run_t r;
        r.level = level;
        r.samples = samples_for(dur_us);
        r.last = last;
        run_queue.push_back(r);
    endfunction

    function automatic void expand_word(logic [1:0] cmd, logic [7:0] data_v);
        int gap_us;
        int rest_us;
        int half_us;
        gap_us = int'(bit_r) - int'(pulse_r);
        rest_us = gap_us - int'(pulse_r);
        half_us = (rest_us > 0) ? rest_us / 2 : 0;
        case (cmd)
            CMD_LEAD:  push_run(silence_r, int'(lead_r), 1'b1);
            CMD_TRAIL: push_run(silence_r, int'(TRAILER_US), 1'b1);
            CMD_DATA:
            begin
                for (int i = 7; i >= 0; i--)
                begin
                    if (data_v[i])
                    begin
                        push_run(low_r, half_us, 1'b0);
                        push_run(high_r, int'(pulse_r), 1'b0);
                        push_run(low_r, half_us, 1'b0);
                    end
                    else
                    begin
                        push_run(low_r, gap_us, 1'b0);
                    end
                    push_run(high_r, int'(pulse_r), i == 0);
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_words
        tape_run_t want;
        int        errs;
        errs = 0;
        if (!rst_n)
        begin
            rate_r       <= 16'd44100;
            bit_r        <= 16'd1600;
            pulse_r      <= 16'd150;
            lead_r       <= 16'd2000;
            high_r       <= 8'd255;
            low_r        <= 8'd127;
            silence_r    <= 8'd127;
            run_queue.delete();
            mismatches   <= 0;
            outstanding  <= 0;
            runs_checked <= 0;
            words_seen   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (run_queue.size() == 0)
                begin
                    $display("%0t: run with nothing expected: level %0d samples %0d last %0d",
                             $time, run_level, run_samples, last_run);
                    errs = 1;
                end
                else
                begin
                    want = run_queue.pop_front();
                    if (run_level !== want.level)
                    begin
                        $display("%0t: run_level expected %0d, got %0d",
                                 $time, want.level, run_level);
                        errs++;
                    end
                    if (run_samples !== want.samples)
                    begin
                        $display("%0t: run_samples expected %0d, got %0d",
                                 $time, want.samples, run_samples);
                        errs++;
                    end
                    if (last_run !== want.last)
                    begin
                        $display("%0t: last_run expected %0d, got %0d",
                                 $time, want.last, last_run);
                        errs++;
                    end
                end
                runs_checked <= runs_checked + 1;
            end
            if (in_valid && in_ready)
            begin
                expand_word(command, data_byte);
                words_seen <= words_seen + 1;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SAMPLE_RATE:   rate_r    <= cfg_data[DUR_W-1:0];
                    REG_BIT_US:        bit_r     <= cfg_data[DUR_W-1:0];
                    REG_PULSE_US:      pulse_r   <= cfg_data[DUR_W-1:0];
                    REG_LEAD_US:       lead_r    <= cfg_data[DUR_W-1:0];
                    REG_HIGH_LEVEL:    high_r    <= cfg_data[LEVEL_W-1:0];
                    REG_LOW_LEVEL:     low_r     <= cfg_data[LEVEL_W-1:0];
                    REG_SILENCE_LEVEL: silence_r <= cfg_data[LEVEL_W-1:0];
                    default: ;
                endcase
            end
            mismatches  <= mismatches + errs;
            outstanding <= run_queue.size();
        end
    end

endmodule

/* tb/tb_tape_bit_pulse_run_encoder.sv */
// Testbench top of the tape bit pulse run encoder: stimulus, output stalls, watchdog and verdict.
module tb_tape_bit_pulse_run_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    import tbpre_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 4;
    localparam int SETTLE_CYCLES   = 10;
    localparam int TAIL_CYCLES     = 20;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int RANDOM_PHASES   = 10;
    localparam int WORDS_PER_PHASE = 25;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [1:0]           command = CMD_LEAD;
    logic [7:0]           data_byte = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [LEVEL_W-1:0]   run_level;
    logic [COUNT_W-1:0]   run_samples;
    logic                 last_run;

    int mismatches;
    int outstanding;
    int runs_checked;
    int words_seen;

    int idle_cycles = 0;
    int ready_hold = 0;
    int ready_pick;
    int lead_sent = 0;
    int data_sent = 0;
    int trail_sent = 0;
    int unused_sent = 0;
    int settings_used = 0;

    tape_bit_pulse_run_encoder i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .run_level   (run_level),
        .run_samples (run_samples),
        .last_run    (last_run)
    );

    tbpre_run_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .run_level    (run_level),
        .run_samples  (run_samples),
        .last_run     (last_run),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .runs_checked (runs_checked),
        .words_seen   (words_seen)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // hold out_ready for a random stretch, mostly short stalls
    always @(posedge clk)
    begin
        if (ready_hold != 0)
        begin
            ready_hold <= ready_hold - 1;
        end
        else
        begin
            ready_pick = $urandom_range(0, 99);
            if (ready_pick < 55)
            begin
                out_ready  <= 1'b1;
                ready_hold <= $urandom_range(0, 15);
            end
            else if (ready_pick < 60)
            begin
                out_ready  <= 1'b1;
                ready_hold <= $urandom_range(100, 300);
            end
            else if (ready_pick < 90)
            begin
                out_ready  <= 1'b0;
                ready_hold <= $urandom_range(0, 2);
            end
            else if (ready_pick < 97)
            begin
                out_ready  <= 1'b0;
                ready_hold <= $urandom_range(3, 10);
            end
            else
            begin
                out_ready  <= 1'b0;
                ready_hold <= $urandom_range(20, 60);
            end
        end
    end

    function automatic int sender_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            return 0;
        end
        else if (pick < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (pick < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 50);
    endfunction

    task automatic send_word(input logic [1:0] cmd, input logic [7:0] data_v);
        int gap;
        in_valid  <= 1'b1;
        command   <= cmd;
        data_byte <= data_v;
        do
            @(posedge clk);
        while (!in_ready);
        case (cmd)
            CMD_LEAD:  lead_sent++;
            CMD_DATA:  data_sent++;
            CMD_TRAIL: trail_sent++;
            default:   unused_sent++;
        endcase
        gap = sender_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic configure(input logic [15:0] rate_v, input logic [15:0] bit_v,
                             input logic [15:0] pulse_v, input logic [15:0] lead_v,
                             input logic [7:0] high_v, input logic [7:0] low_v,
                             input logic [7:0] silence_v);
        wait_idle();
        // let a word that gives no run finish
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_SAMPLE_RATE, rate_v);
        write_reg(REG_BIT_US, bit_v);
        write_reg(REG_PULSE_US, pulse_v);
        if ($urandom_range(0, 1) == 1)
        begin
            write_reg(REG_UNUSED, 16'($urandom));
        end
        write_reg(REG_LEAD_US, lead_v);
        write_reg(REG_HIGH_LEVEL, {8'($urandom), high_v});
        write_reg(REG_LOW_LEVEL, {8'($urandom), low_v});
        write_reg(REG_SILENCE_LEVEL, {8'($urandom), silence_v});
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    task automatic random_setting();
        logic [15:0] rate_v;
        logic [15:0] bit_v;
        logic [15:0] pulse_v;
        logic [15:0] lead_v;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            rate_v = 16'($urandom_range(8000, 48000));
        else if (pick < 80)
            rate_v = pick[0] ? 16'd48000 : 16'd8000;
        else if (pick < 85)
            rate_v = 16'd0;
        else if (pick < 90)
            rate_v = 16'($urandom_range(62500, 65535));
        else
            rate_v = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 60)
            bit_v = 16'($urandom_range(200, 4000));
        else if (pick < 75)
            bit_v = 16'($urandom_range(0, 400));
        else if (pick < 90)
            bit_v = 16'($urandom);
        else
            bit_v = pick[0] ? 16'hFFFF : 16'h0000;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            pulse_v = 16'($urandom_range(50, 600));
        else if (pick < 80)
            pulse_v = 16'($urandom_range(0, int'(bit_v)));
        else
            pulse_v = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 70)
            lead_v = 16'($urandom_range(0, 20000));
        else
            lead_v = 16'($urandom);
        configure(rate_v, bit_v, pulse_v, lead_v, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int phase_end;
        int block_len;
        int shape;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset register values
        send_word(CMD_LEAD, 8'h00);
        send_word(CMD_TRAIL, 8'hFF);
        send_word(CMD_DATA, 8'h00);
        send_word(CMD_DATA, 8'hFF);
        send_word(CMD_DATA, 8'hA5);
        send_word(CMD_DATA, 8'h5A);
        send_word(CMD_DATA, 8'h80);
        send_word(CMD_DATA, 8'h01);
        send_word(CMD_UNUSED, 8'hFF);
        send_word(CMD_UNUSED, 8'h00);

        // gap positive, half gap negative
        configure(16'd48000, 16'd250, 16'd150, 16'd0, 8'd0, 8'd255, 8'd0);
        send_word(CMD_DATA, 8'hFF);
        send_word(CMD_DATA, 8'h00);
        send_word(CMD_LEAD, 8'h3C);

        // whole gap negative
        configure(16'd8000, 16'd100, 16'd150, 16'd65535, 8'd255, 8'd0, 8'd255);
        send_word(CMD_DATA, 8'h96);
        send_word(CMD_LEAD, 8'h00);
        send_word(CMD_TRAIL, 8'h00);

        // saturating counts
        configure(16'd65535, 16'd65535, 16'd0, 16'd65535, 8'd128, 8'd1, 8'd254);
        send_word(CMD_DATA, 8'h0F);
        send_word(CMD_LEAD, 8'hFF);
        send_word(CMD_TRAIL, 8'h55);

        // zero sample rate, odd half gap
        configure(16'd0, 16'd65535, 16'd301, 16'd65535, 8'd255, 8'd255, 8'd255);
        send_word(CMD_DATA, 8'hC3);
        send_word(CMD_LEAD, 8'hAA);

        // half gap truncation down to one sample
        configure(16'd20000, 16'd301, 16'd100, 16'd1, 8'd0, 8'd0, 8'd0);
        send_word(CMD_DATA, 8'hFF);
        send_word(CMD_TRAIL, 8'h7E);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            random_setting();
            phase_end = lead_sent + data_sent + trail_sent + WORDS_PER_PHASE;
            while (lead_sent + data_sent + trail_sent < phase_end)
            begin
                shape = $urandom_range(0, 99);
                if (shape < 80)
                begin
                    send_word(CMD_LEAD, 8'($urandom));
                    block_len = $urandom_range(1, 6);
                    repeat (block_len)
                    begin
                        if ($urandom_range(0, 19) == 0)
                        begin
                            send_word(CMD_UNUSED, 8'($urandom));
                        end
                        send_word(CMD_DATA, 8'($urandom));
                    end
                    send_word(CMD_TRAIL, 8'($urandom));
                end
                else if (shape < 93)
                begin
                    send_word(2'($urandom_range(0, 2)), 8'($urandom));
                end
                else
                begin
                    send_word(CMD_UNUSED, 8'($urandom));
                end
                if ($urandom_range(0, 29) == 0)
                begin
                    wait_idle();
                end
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Covered %0d words (%0d lead-in, %0d data, %0d trailer, %0d unused)",
                 words_seen, lead_sent, data_sent, trail_sent, unused_sent);
        $display("Checked %0d runs over %0d settings, %0d mismatches, %0d runs still expected",
                 runs_checked, settings_used + 1, mismatches, outstanding);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* tape_bit_pulse_run_encoder.f */
rtl/core/tbpre_pkg.sv
rtl/core/tape_bit_pulse_run_encoder.sv
tb/tbpre_run_checker.sv
tb/tb_tape_bit_pulse_run_encoder.sv
